// File: sv/dsga_pkg.sv
// Shared types and constants for the direct-sum gravity accumulator.
// No dependencies; every other file imports this package.
package dsga_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 32;
    localparam int IDX_W      = 12;
    localparam int MAG_W      = 32;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int R_W        = 50;
    localparam int ROOT_W     = 34;
    localparam int SQX_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int CHUNK_W    = ROOT_W / 2;
    localparam int DEN_W      = 84;
    localparam int NUM_W      = 96;
    localparam int Q_W        = 32;
    localparam int SUM_W      = 48;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_GRAV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAW  = 2'd3;

    localparam logic [CFG_W-1:0] GRAV_RESET = 32'd1310720;
    localparam logic [CFG_W-1:0] MASS_RESET = 32'd65536;

    typedef struct packed {
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic [IDX_W-1:0]        target_index;
        logic signed [POS_W-1:0] source_x;
        logic signed [POS_W-1:0] source_y;
        logic [IDX_W-1:0]        source_index;
        logic                    first_source;
        logic                    last_source;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] accel_x;
        logic signed [POS_W-1:0] accel_y;
        logic                    saturated;
    } t_out_item;

    typedef enum logic [1:0] {
        MUL_DEN,
        MUL_NUMX,
        MUL_NUMY
    } t_mul_sel;

    typedef struct packed {
        logic     accept;
        logic     diff_en;
        logic     sq_en;
        logic     rsum_en;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     den_2d_load;
        logic     mul_en;
        logic     mul_hi;
        t_mul_sel mul_sel;
        logic     div_load;
        logic     div_step;
        logic     acc_en;
        logic     zero_sat;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic self_pair;
        logic r_zero;
        logic law_2d;
        logic last;
    } t_sts;

endpackage

// File: sv/dsga_div.sv
// One restoring divider lane: quotient bits 31..0, one bit per step.
// Bit 31 set means the true quotient reached 2^31. Depends on dsga_pkg.
module dsga_div (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic [dsga_pkg::NUM_W-1:0]    i_num,
    input  logic [dsga_pkg::DEN_W-1:0]    i_den,
    output logic [dsga_pkg::Q_W-1:0]      o_quot
);
    import dsga_pkg::*;

    localparam int DS_W = DEN_W + DIV_STEPS - 1;

    logic [NUM_W-1:0] r_rem;
    logic [DS_W-1:0]  r_dsh;
    logic [Q_W-1:0]   r_quot;
    logic             ge;

    assign ge     = DS_W'(r_rem) >= r_dsh;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= i_num;
            r_dsh  <= DS_W'(i_den) << (DIV_STEPS - 1);
            r_quot <= '0;
        end else if (i_step) begin
            if (ge) begin
                r_rem <= r_rem - NUM_W'(r_dsh);
            end
            r_quot <= {r_quot[Q_W-2:0], ge};
            r_dsh  <= r_dsh >> 1;
        end
    end

endmodule

// File: sv/dsga_dpath.sv
// Datapath: config registers, item register, distance, square root, shared
// 64x17 multiplier, two divider lanes and the saturating sums. Uses dsga_pkg, dsga_div.
module dsga_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dsga_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dsga_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  dsga_pkg::t_in_item               i_item,
    input  dsga_pkg::t_cmd                   i_cmd,
    output dsga_pkg::t_sts                   o_sts,
    output dsga_pkg::t_out_item              o_result
);
    import dsga_pkg::*;

    logic [CFG_W-1:0]  r_grav, r_mass, r_soft;
    logic              r_law;
    t_in_item          r_item;
    logic              r_neg_x, r_neg_y;
    logic [MAG_W-1:0]  r_mag_x, r_mag_y;
    logic [SQ_W-1:0]   r_sqx, r_sqy, r_prod;
    logic [R_W-1:0]    r_r;
    logic [SQX_W-1:0]  r_sx;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_numx, r_numy;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic              r_sat;
    t_out_item         r_out;

    logic signed [POS_W:0]   dx, dy;
    logic [REM_W-1:0]        sq_rem_sh, sq_trial;
    logic [SQ_W-1:0]         mul_a;
    logic [ROOT_W-1:0]       mul_b_full;
    logic [CHUNK_W-1:0]      mul_b;
    logic [SQ_W+CHUNK_W-1:0] mul_p;
    logic [NUM_W-1:0]        mul_p_sh;
    logic [Q_W-1:0]          quot_x, quot_y, qx, qy;
    logic                    clamp_x, clamp_y;
    logic signed [Q_W:0]     term_x, term_y;
    logic signed [SUM_W:0]   sumx_w, sumy_w;
    logic                    ovf_x, ovf_y, oclip_x, oclip_y;
    logic signed [SUM_W-1:0] sumx_sat, sumy_sat;

    assign dx = {r_item.target_x[POS_W-1], r_item.target_x}
              - {r_item.source_x[POS_W-1], r_item.source_x};
    assign dy = {r_item.target_y[POS_W-1], r_item.target_y}
              - {r_item.source_y[POS_W-1], r_item.source_y};

    assign o_sts.self_pair = r_item.target_index == r_item.source_index;
    assign o_sts.r_zero    = r_r == '0;
    assign o_sts.law_2d    = r_law;
    assign o_sts.last      = r_item.last_source;
    assign o_result        = r_out;

    // square root: two radicand bits per step
    assign sq_rem_sh = {r_rem[REM_W-3:0], r_sx[SQX_W-1 -: 2]};
    assign sq_trial  = {1'b0, r_root, 2'b01};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DEN: begin
                mul_a      = SQ_W'(r_r);
                mul_b_full = r_root;
            end
            MUL_NUMX: begin
                mul_a      = r_prod;
                mul_b_full = ROOT_W'(r_mag_x);
            end
            MUL_NUMY: begin
                mul_a      = r_prod;
                mul_b_full = ROOT_W'(r_mag_y);
            end
            default: begin
                mul_a      = '0;
                mul_b_full = '0;
            end
        endcase
    end

    assign mul_b    = i_cmd.mul_hi ? mul_b_full[ROOT_W-1:CHUNK_W] : mul_b_full[CHUNK_W-1:0];
    assign mul_p    = (SQ_W+CHUNK_W)'(mul_a) * (SQ_W+CHUNK_W)'(mul_b);
    assign mul_p_sh = i_cmd.mul_hi ? (NUM_W'(mul_p) << CHUNK_W) : NUM_W'(mul_p);

    dsga_div u_div_x (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (r_numx),
        .i_den  (r_den),
        .o_quot (quot_x)
    );

    dsga_div u_div_y (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (r_numy),
        .i_den  (r_den),
        .o_quot (quot_y)
    );

    // clamp the term magnitude; the term opposes the offset
    assign clamp_x = quot_x[Q_W-1];
    assign clamp_y = quot_y[Q_W-1];
    assign qx      = clamp_x ? {1'b0, {(Q_W-1){1'b1}}} : quot_x;
    assign qy      = clamp_y ? {1'b0, {(Q_W-1){1'b1}}} : quot_y;
    assign term_x  = r_neg_x ? $signed({1'b0, qx}) : -$signed({1'b0, qx});
    assign term_y  = r_neg_y ? $signed({1'b0, qy}) : -$signed({1'b0, qy});
    assign sumx_w  = (SUM_W+1)'(r_sum_x) + (SUM_W+1)'(term_x);
    assign sumy_w  = (SUM_W+1)'(r_sum_y) + (SUM_W+1)'(term_y);
    assign ovf_x   = sumx_w[SUM_W] != sumx_w[SUM_W-1];
    assign ovf_y   = sumy_w[SUM_W] != sumy_w[SUM_W-1];
    assign sumx_sat = ovf_x ? {sumx_w[SUM_W], {(SUM_W-1){~sumx_w[SUM_W]}}}
                            : sumx_w[SUM_W-1:0];
    assign sumy_sat = ovf_y ? {sumy_w[SUM_W], {(SUM_W-1){~sumy_w[SUM_W]}}}
                            : sumy_w[SUM_W-1:0];

    assign oclip_x = !((&r_sum_x[SUM_W-1:POS_W-1]) || !(|r_sum_x[SUM_W-1:POS_W-1]));
    assign oclip_y = !((&r_sum_y[SUM_W-1:POS_W-1]) || !(|r_sum_y[SUM_W-1:POS_W-1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav  <= GRAV_RESET;
            r_mass  <= MASS_RESET;
            r_soft  <= '0;
            r_law   <= 1'b0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRAV: r_grav <= i_cfg_wdata;
                    CFG_MASS: r_mass <= i_cfg_wdata;
                    CFG_SOFT: r_soft <= i_cfg_wdata;
                    CFG_LAW:  r_law  <= i_cfg_wdata[0];
                    default:  r_law  <= r_law;
                endcase
            end
            if (i_cmd.accept && i_item.first_source) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_sat   <= 1'b0;
            end else if (i_cmd.acc_en) begin
                r_sum_x <= sumx_sat;
                r_sum_y <= sumy_sat;
                r_sat   <= r_sat | clamp_x | clamp_y | ovf_x | ovf_y;
            end else if (i_cmd.zero_sat) begin
                r_sat <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (i_cmd.diff_en) begin
            r_neg_x <= dx[POS_W];
            r_neg_y <= dy[POS_W];
            r_mag_x <= dx[POS_W] ? MAG_W'(-dx) : MAG_W'(dx);
            r_mag_y <= dy[POS_W] ? MAG_W'(-dy) : MAG_W'(dy);
        end
        if (i_cmd.sq_en) begin
            r_sqx  <= SQ_W'(r_mag_x) * SQ_W'(r_mag_x);
            r_sqy  <= SQ_W'(r_mag_y) * SQ_W'(r_mag_y);
            r_prod <= SQ_W'(r_grav) * SQ_W'(r_mass);
        end
        if (i_cmd.rsum_en) begin
            r_r <= R_W'(r_sqx >> FRAC_BITS) + R_W'(r_sqy >> FRAC_BITS) + R_W'(r_soft);
        end
        if (i_cmd.sqrt_load) begin
            r_sx   <= SQX_W'(r_r) << FRAC_BITS;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sx <= r_sx << 2;
            if (sq_rem_sh >= sq_trial) begin
                r_rem  <= sq_rem_sh - sq_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= sq_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.den_2d_load) begin
            r_den <= DEN_W'(r_r) << (FRAC_BITS - 1);
        end else if (i_cmd.mul_en && i_cmd.mul_sel == MUL_DEN) begin
            r_den <= i_cmd.mul_hi ? r_den + DEN_W'(mul_p_sh) : DEN_W'(mul_p_sh);
        end
        if (i_cmd.mul_en && i_cmd.mul_sel == MUL_NUMX) begin
            r_numx <= i_cmd.mul_hi ? r_numx + mul_p_sh : mul_p_sh;
        end
        if (i_cmd.mul_en && i_cmd.mul_sel == MUL_NUMY) begin
            r_numy <= i_cmd.mul_hi ? r_numy + mul_p_sh : mul_p_sh;
        end
        if (i_cmd.out_load) begin
            r_out.accel_x   <= oclip_x ? {r_sum_x[SUM_W-1], {(POS_W-1){~r_sum_x[SUM_W-1]}}}
                                       : r_sum_x[POS_W-1:0];
            r_out.accel_y   <= oclip_y ? {r_sum_y[SUM_W-1], {(POS_W-1){~r_sum_y[SUM_W-1]}}}
                                       : r_sum_y[POS_W-1:0];
            r_out.saturated <= r_sat | oclip_x | oclip_y;
        end
    end

endmodule

// File: sv/dsga_ctrl.sv
// Sequencer for one pair: distance, square root, multiplies, division,
// accumulate, emit. Holds the output valid flag. Depends on dsga_pkg.
module dsga_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  dsga_pkg::t_sts i_sts,
    output dsga_pkg::t_cmd o_cmd
);
    import dsga_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_SQ, S_RSUM, S_CHECK, S_SQRT, S_DEN0, S_DEN1,
        S_NUMX0, S_NUMX1, S_NUMY0, S_NUMY1, S_DIVLD, S_DIV, S_ACC, S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state       = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_en = 1'b1;
                n_state     = S_RSUM;
            end
            S_RSUM: begin
                o_cmd.rsum_en = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.self_pair) begin
                    n_state = S_FIN;
                end else if (i_sts.r_zero) begin
                    // coincident pair: drop it, flag saturation
                    o_cmd.zero_sat = 1'b1;
                    n_state        = S_FIN;
                end else if (i_sts.law_2d) begin
                    o_cmd.den_2d_load = 1'b1;
                    n_state           = S_NUMX0;
                end else begin
                    o_cmd.sqrt_load = 1'b1;
                    n_cnt           = CNT_W'(SQRT_STEPS - 1);
                    n_state         = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DEN0;
                end
            end
            S_DEN0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DEN;
                n_state       = S_DEN1;
            end
            S_DEN1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_hi  = 1'b1;
                o_cmd.mul_sel = MUL_DEN;
                n_state       = S_NUMX0;
            end
            S_NUMX0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NUMX;
                n_state       = S_NUMX1;
            end
            S_NUMX1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_hi  = 1'b1;
                o_cmd.mul_sel = MUL_NUMX;
                n_state       = S_NUMY0;
            end
            S_NUMY0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NUMY;
                n_state       = S_NUMY1;
            end
            S_NUMY1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_hi  = 1'b1;
                o_cmd.mul_sel = MUL_NUMY;
                n_state       = S_DIVLD;
            end
            S_DIVLD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = CNT_W'(DIV_STEPS - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // a last-source pair holds until the output register is free
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: sv/direct_sum_gravity_accumulator.sv
// Top level of the direct-sum gravity accumulator: controller plus datapath.
// Depends on dsga_pkg, dsga_ctrl, dsga_dpath.

// Each item is one target/source pair; the block takes one pair at a time.
// A 3D-law pair runs the bit-pair square root, the division (x and y lanes
// run side by side) and the shared 64x17 multiplier that forms the denominator
// and both numerators. A 2D-law pair skips the square root and the denominator
// multiplies; a self pair or one at zero distance skips all three. The result
// item of a last-source pair sits in an output register, so the next pair is
// accepted while it waits. Configuration is written through a plain write port;
// the user must write it only while the block is idle; it is not enforced.
module direct_sum_gravity_accumulator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dsga_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dsga_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dsga_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dsga_pkg::t_out_item             o_out_data
);
    import dsga_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dsga_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dsga_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_out_data)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready still high after an item was taken");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result overwrote an item not yet taken");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.sqrt_step && cmd.div_step) && !(cmd.accept && cmd.acc_en))
        else $error("overlapping datapath commands");
`endif

endmodule
